/* hw/rtl/utf8n_pkg.sv */
// Package for the UTF-8 text normalizer.
// Holds the result group type passed from the decoder to the output queue,
// and the reset and sizing constants. No dependencies.
package utf8n_pkg;

	// Reset value of the character limit register.
	localparam logic [7:0] MAX_CHARS_RESET = 8'd20;

	// Default number of result groups the output queue holds.
	localparam int GROUP_DEPTH_DEFAULT = 4;

	// Most bytes one input beat can release: a pending space and a 4-byte character.
	localparam int GROUP_BYTES = 5;

	// All result beats released by one input beat, sent out one byte per beat.
	typedef struct packed {
		logic [GROUP_BYTES-1:0][7:0] bytes;
		logic [2:0]                  nbytes;    // 1 .. GROUP_BYTES
		logic                        has_byte;  // 0 for a bare end marker
		logic                        last;      // group closes the string
		logic                        empty;     // nothing kept in the string
	} utf8n_group_t;

	// Decoder to queue handoff.
	typedef struct packed {
		logic         push;
		utf8n_group_t group;
	} utf8n_push_t;

endpackage

/* hw/rtl/utf8n_decode.sv */
// UTF-8 decode, filter and whitespace collapse for the text normalizer.
// Registers each input beat, updates the per-string state and hands a result
// group to the output queue for each beat that keeps a character or closes a string. Depends on utf8n_pkg.
module utf8n_decode
	import utf8n_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [7:0]  cfg_wr_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  in_byte,
	input  logic        in_last,
	input  logic        queue_full,
	output utf8n_push_t push
);

	localparam logic [7:0]  ASCII_SPACE = 8'h20;
	localparam logic [20:0] CP_DEL      = 21'h7F;
	localparam logic [20:0] CP_C0_END   = 21'h20;
	localparam logic [20:0] CP_SURR_LO  = 21'hD800;
	localparam logic [20:0] CP_SURR_HI  = 21'hDFFF;
	localparam logic [20:0] CP_MAX      = 21'h10FFFF;

	function automatic logic is_space_cp(input logic [20:0] cp);
		return cp == 21'h20 || (cp >= 21'h09 && cp <= 21'h0D) || cp == 21'h85 ||
		       cp == 21'hA0 || cp == 21'h1680 || (cp >= 21'h2000 && cp <= 21'h200A) ||
		       cp == 21'h2028 || cp == 21'h2029 || cp == 21'h202F ||
		       cp == 21'h205F || cp == 21'h3000;
	endfunction

	logic [7:0]       max_chars_q;
	logic             valid_s1;
	logic [7:0]       byte_s1;
	logic             last_s1;
	logic             advance;

	logic [3:0][7:0]  seq_bytes_q, cur_bytes;
	logic [2:0]       seq_len_q, seq_len_n;
	logic [2:0]       seq_pos_q, seq_pos_n;
	logic [20:0]      acc_q, acc_n;
	logic             pend_q, pend_n;
	logic             after_q, after_n;
	logic [7:0]       count_q, count_n;
	logic             kept_q, kept_n;

	logic             have_char, bad_seq, emit;
	logic [20:0]      char_cp;
	logic [2:0]       char_n;
	utf8n_group_t     grp;

	assign advance  = valid_s1 && !queue_full;
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_chars_q <= MAX_CHARS_RESET;
		end else if (cfg_wr_en) begin
			max_chars_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= in_byte;
			last_s1 <= in_last;
		end
	end

	always_comb begin
		cur_bytes = seq_bytes_q;
		seq_len_n = seq_len_q;
		seq_pos_n = seq_pos_q;
		acc_n     = acc_q;
		have_char = 1'b0;
		bad_seq   = 1'b0;
		char_cp   = '0;
		char_n    = 3'd0;

		if (seq_len_q != 3'd0 && byte_s1[7:6] == 2'b10) begin
			// Continuation byte of an open sequence.
			cur_bytes[seq_pos_q[1:0]] = byte_s1;
			acc_n     = {acc_q[14:0], byte_s1[5:0]};
			seq_pos_n = seq_pos_q + 3'd1;
			if (seq_pos_n >= seq_len_q) begin
				bad_seq = (seq_len_q == 3'd2 && acc_n < 21'h80) ||
				          (seq_len_q == 3'd3 && acc_n < 21'h800) ||
				          (seq_len_q == 3'd4 && acc_n < 21'h10000) ||
				          (acc_n >= CP_SURR_LO && acc_n <= CP_SURR_HI) ||
				          acc_n > CP_MAX;
				seq_len_n = 3'd0;
				seq_pos_n = 3'd0;
				have_char = !bad_seq;
				char_cp   = acc_n;
				char_n    = seq_len_q;
			end
		end else begin
			// No sequence open, or a broken one: the byte starts afresh.
			seq_len_n    = 3'd0;
			seq_pos_n    = 3'd0;
			cur_bytes[0] = byte_s1;
			priority if (!byte_s1[7]) begin
				have_char = 1'b1;
				char_cp   = {13'd0, byte_s1};
				char_n    = 3'd1;
			end else if (byte_s1[7:5] == 3'b110) begin
				seq_len_n = 3'd2;
				seq_pos_n = 3'd1;
				acc_n     = {16'd0, byte_s1[4:0]};
			end else if (byte_s1[7:4] == 4'b1110) begin
				seq_len_n = 3'd3;
				seq_pos_n = 3'd1;
				acc_n     = {17'd0, byte_s1[3:0]};
			end else if (byte_s1[7:3] == 5'b11110) begin
				seq_len_n = 3'd4;
				seq_pos_n = 3'd1;
				acc_n     = {18'd0, byte_s1[2:0]};
			end else begin
				// Stray continuation or invalid lead: dropped.
			end
		end
	end

	always_comb begin
		pend_n  = pend_q;
		after_n = after_q;
		count_n = count_q;
		kept_n  = kept_q;
		emit    = 1'b0;
		if (have_char) begin
			if (is_space_cp(char_cp)) begin
				if (!after_q && count_q < max_chars_q) begin
					pend_n  = 1'b1;
					after_n = 1'b1;
					count_n = count_q + 8'd1;
				end
			end else if (!(char_cp < CP_C0_END || char_cp == CP_DEL) &&
			             count_q < max_chars_q) begin
				emit    = 1'b1;
				pend_n  = 1'b0;
				after_n = 1'b0;
				count_n = count_q + 8'd1;
				kept_n  = 1'b1;
			end
		end
	end

	always_comb begin
		grp          = '0;
		grp.has_byte = emit;
		grp.last     = last_s1;
		grp.empty    = last_s1 && !kept_n;
		if (emit) begin
			if (pend_q) begin
				grp.bytes[0] = ASCII_SPACE;
				for (int i = 1; i < GROUP_BYTES; i++) begin
					grp.bytes[i] = cur_bytes[i-1];
				end
				grp.nbytes = char_n + 3'd1;
			end else begin
				for (int i = 0; i < GROUP_BYTES - 1; i++) begin
					grp.bytes[i] = cur_bytes[i];
				end
				grp.nbytes = char_n;
			end
		end else begin
			// Bare end marker when the closing beat releases nothing.
			grp.nbytes = 3'd1;
		end
		push.push  = advance && (emit || last_s1);
		push.group = grp;
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			seq_bytes_q <= cur_bytes;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_len_q <= 3'd0;
			seq_pos_q <= 3'd0;
			acc_q     <= '0;
			pend_q    <= 1'b0;
			after_q   <= 1'b1;
			count_q   <= 8'd0;
			kept_q    <= 1'b0;
		end else if (advance) begin
			if (last_s1) begin
				seq_len_q <= 3'd0;
				seq_pos_q <= 3'd0;
				acc_q     <= '0;
				pend_q    <= 1'b0;
				after_q   <= 1'b1;
				count_q   <= 8'd0;
				kept_q    <= 1'b0;
			end else begin
				seq_len_q <= seq_len_n;
				seq_pos_q <= seq_pos_n;
				acc_q     <= acc_n;
				pend_q    <= pend_n;
				after_q   <= after_n;
				count_q   <= count_n;
				kept_q    <= kept_n;
			end
		end
	end

endmodule

/* hw/rtl/utf8n_group_fifo.sv */
// Output queue of result groups for the UTF-8 text normalizer.
// Stores whole groups and sends them out one byte per beat.
// Depends on utf8n_pkg.
module utf8n_group_fifo
	import utf8n_pkg::*;
#(
	parameter int DEPTH = GROUP_DEPTH_DEFAULT
) (
	input  logic        clk,
	input  logic        arst_n,
	input  utf8n_push_t push,
	output logic        full,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  out_byte,
	output logic        out_has_byte,
	output logic        out_last,
	output logic        out_empty
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	utf8n_group_t          mem [DEPTH];
	logic [PTR_W-1:0]      wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0]      count_q;
	logic [2:0]            idx_q;
	utf8n_group_t          head;
	logic                  final_byte, pop;

	assign head       = mem[rd_ptr_q];
	assign full       = count_q == CNT_W'(DEPTH);
	assign out_valid  = count_q != '0;
	assign final_byte = idx_q == head.nbytes - 3'd1;
	assign pop        = out_valid && out_ready && final_byte;

	assign out_byte     = head.bytes[idx_q];
	assign out_has_byte = head.has_byte;
	assign out_last     = head.last && final_byte;
	assign out_empty    = head.empty && final_byte;

	always_ff @(posedge clk) begin
		if (push.push) begin
			mem[wr_ptr_q] <= push.group;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
			idx_q    <= 3'd0;
		end else begin
			if (push.push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (push.push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push.push) begin
				count_q <= count_q - CNT_W'(1);
			end
			if (out_valid && out_ready) begin
				idx_q <= final_byte ? 3'd0 : idx_q + 3'd1;
			end
		end
	end

endmodule

/* hw/rtl/utf8_text_normalizer.sv */
// Top level of the UTF-8 text normalizer.
// Connects the decode stage to the output group queue.
// Depends on utf8n_pkg, utf8n_decode and utf8n_group_fifo.
//
//   channel  direction  beat contents
//   s_axis   in         tdata[7:0] raw byte, tlast end of string
//   m_axis   out        tdata[7:0] byte, tuser[0] has byte, tuser[1] empty, tlast
//   cfg      in         cfg_wr_data: character limit, written when cfg_wr_en
//
// One input beat is taken per cycle while the group queue is not full. A taken
// byte is held and decoded in the input register, and its group is then written
// into the queue, from which its first output beat is read.
// The group of one input beat holds up to five bytes (a pending space and a
// four-byte character), sent one byte per cycle while m_axis_tready is high.
// Input stalls only when the group queue (GROUP_DEPTH groups) is full.
// Reset clears the per-string state and sets the limit to 20 characters.
module utf8_text_normalizer
	import utf8n_pkg::*;
#(
	parameter int GROUP_DEPTH = GROUP_DEPTH_DEFAULT
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_wr_en,
	input  logic [7:0] cfg_wr_data,
	input  logic       s_axis_tvalid,
	output logic       s_axis_tready,
	input  logic [7:0] s_axis_tdata,   // [7:0] in_byte
	input  logic       s_axis_tlast,
	output logic       m_axis_tvalid,
	input  logic       m_axis_tready,
	output logic [7:0] m_axis_tdata,   // [7:0] out_byte
	output logic [1:0] m_axis_tuser,   // [0] out_has_byte, [1] out_empty
	output logic       m_axis_tlast
);

	utf8n_push_t push;
	logic        queue_full;

	utf8n_decode u_decode (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.in_valid   (s_axis_tvalid),
		.in_ready   (s_axis_tready),
		.in_byte    (s_axis_tdata),
		.in_last    (s_axis_tlast),
		.queue_full (queue_full),
		.push       (push)
	);

	utf8n_group_fifo #(
		.DEPTH(GROUP_DEPTH)
	) u_fifo (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (queue_full),
		.out_valid   (m_axis_tvalid),
		.out_ready   (m_axis_tready),
		.out_byte    (m_axis_tdata),
		.out_has_byte(m_axis_tuser[0]),
		.out_last    (m_axis_tlast),
		.out_empty   (m_axis_tuser[1])
	);

endmodule
